FILE: rtl/core/pfs_pkg.sv
// shared types, constants and tables of the planar fibre stress block
`default_nettype none
package pfs_pkg;

	localparam int ADDR_W = 5;
	localparam int U_W    = 36;
	localparam int T1_W   = 52;
	localparam int SQ_W   = 61;
	localparam int A_W    = 37;
	localparam int E_W    = 62;
	localparam int T2_W   = 62;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [29:0] LN2_Q30   = 30'd744261118;

	typedef enum logic [2:0] {
		REG_STIFFNESS = 3'd0,
		REG_EXPONENT  = 3'd1,
		REG_FIBER_XX  = 3'd2,
		REG_FIBER_XY  = 3'd3,
		REG_FIBER_YY  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        [31:0] stiffness_gain;
		logic        [31:0] exponent_gain;
		logic signed [31:0] fiber_xx;
		logic signed [31:0] fiber_xy;
		logic signed [31:0] fiber_yy;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] c_xx;
		logic signed [31:0] c_xy;
		logic signed [31:0] c_yx;
		logic signed [31:0] c_yy;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] stress_xx;
		logic signed [31:0] stress_xy;
		logic signed [31:0] stress_yy;
		logic               saturated;
	} result_t;

	// sign of the invariant and k1 * |invariant|, carried beside the exponential
	typedef struct packed {
		logic            neg;
		logic [T1_W-1:0] t1;
	} side_t;

	// taylor coefficients of e^(z) in q30
	function automatic logic [31:0] taylor_coef(input logic [2:0] k);
		logic [31:0] c;
		case (k) inside
			3'd0, 3'd1: c = 32'd1073741824;
			3'd2:       c = 32'd536870912;
			3'd3:       c = 32'd178956971;
			3'd4:       c = 32'd44739243;
			3'd5:       c = 32'd8947849;
			3'd6:       c = 32'd1491308;
			default:    c = 32'd0;
		endcase
		return c;
	endfunction

	// 2^(i/4) in q1.30
	function automatic logic [30:0] pow2_quarter(input logic [1:0] i);
		logic [30:0] p;
		case (i)
			2'd0:    p = 31'd1073741824;
			2'd1:    p = 31'd1276901417;
			2'd2:    p = 31'd1518500250;
			default: p = 31'd1805811301;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pfs_if.sv
// item channels of the planar fibre stress block
`default_nettype none
interface pfs_sample_if;
	import pfs_pkg::*;
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pfs_result_if;
	import pfs_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pfs_apb.sv
// apb register file holding gains and fibre weights
`default_nettype none
module pfs_apb (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pfs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output pfs_pkg::cfg_t              cfg
);
	import pfs_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stiffness_gain <= 32'd65536;
			cfg_q.exponent_gain  <= 32'd16777216;
			cfg_q.fiber_xx       <= 32'sd1073741824;
			cfg_q.fiber_xy       <= 32'sd0;
			cfg_q.fiber_yy       <= 32'sd0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_STIFFNESS: cfg_q.stiffness_gain <= pwdata;
				REG_EXPONENT:  cfg_q.exponent_gain  <= pwdata;
				REG_FIBER_XX:  cfg_q.fiber_xx       <= pwdata;
				REG_FIBER_XY:  cfg_q.fiber_xy       <= pwdata;
				REG_FIBER_YY:  cfg_q.fiber_yy       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STIFFNESS: prdata = cfg_q.stiffness_gain;
			REG_EXPONENT:  prdata = cfg_q.exponent_gain;
			REG_FIBER_XX:  prdata = cfg_q.fiber_xx;
			REG_FIBER_XY:  prdata = cfg_q.fiber_xy;
			REG_FIBER_YY:  prdata = cfg_q.fiber_yy;
			default:       prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

FILE: rtl/core/pfs_inv.sv
// invariant, squared invariant and exponent argument pipeline
`default_nettype none
module pfs_inv #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  pfs_pkg::sample_t         in_data,
	input  pfs_pkg::cfg_t            cfg,
	output logic                     out_valid,
	output logic [FRACTION_BITS+4:0] y,
	output logic                     big,
	output pfs_pkg::side_t           side
);
	import pfs_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int Y_W = F + 5;
	localparam logic signed [36:0] ONE_Q  = 37'(64'd1 << F);
	localparam logic [SQ_W-1:0]    SQ_CAP = SQ_W'(64'd1 << (F + 30));
	localparam logic [A_W-1:0]     A_CAP  = A_W'(64'd1 << (F + 6));
	localparam logic [37:0]        LIMIT  = 38'(64'd32 << F);

	logic                    v_s [1:12];
	logic signed [63:0]      p_xx_s1, p_xy_s1, p_yx_s1, p_yy_s1;
	logic signed [36:0]      i4_s2;
	logic                    neg_s3, neg_s4;
	logic [U_W-1:0]          u_s3;
	logic [63:0]             sq_ll_s4, k1_l_s4;
	logic [35:0]             sq_lh_s4, k1_h_s4;
	logic [7:0]              sq_hh_s4;
	logic [71:0]             sq_s5;
	logic [SQ_W-1:0]         sqc_s6;
	logic [63:0]             a_l_s7;
	logic [60:0]             a_h_s7;
	logic [68:0]             a_s8;
	logic [A_W-1:0]          ac_s9;
	logic [62:0]             y_l_s10;
	logic [35:0]             y_h_s10;
	logic [37:0]             y_s11;
	logic [Y_W-1:0]          y_s12;
	logic                    big_s12;
	side_t                   side_s [5:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 12; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= 12; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// weighted contraction, floored to the working fraction
			p_xx_s1 <= cfg.fiber_xx * in_data.c_xx;
			p_xy_s1 <= cfg.fiber_xy * in_data.c_xy;
			p_yx_s1 <= cfg.fiber_xy * in_data.c_yx;
			p_yy_s1 <= cfg.fiber_yy * in_data.c_yy;
			i4_s2   <= 37'(p_xx_s1 >>> 30) + 37'(p_xy_s1 >>> 30)
			         + 37'(p_yx_s1 >>> 30) + 37'(p_yy_s1 >>> 30) - ONE_Q;
			neg_s3  <= i4_s2[36];
			u_s3    <= i4_s2[36] ? U_W'(-i4_s2) : U_W'(i4_s2);
			// u squared and k1 * u as split products
			neg_s4   <= neg_s3;
			sq_ll_s4 <= u_s3[31:0] * u_s3[31:0];
			sq_lh_s4 <= u_s3[31:0] * u_s3[35:32];
			sq_hh_s4 <= u_s3[35:32] * u_s3[35:32];
			k1_l_s4  <= u_s3[31:0] * cfg.stiffness_gain;
			k1_h_s4  <= u_s3[35:32] * cfg.stiffness_gain;
			sq_s5    <= 72'(sq_ll_s4) + (72'(sq_lh_s4) << 33) + (72'(sq_hh_s4) << 64);
			side_s[5].neg <= neg_s4;
			side_s[5].t1  <= T1_W'((68'(k1_l_s4) + (68'(k1_h_s4) << 32)) >> 16);
			// beyond this bound the exponential overflows whenever k2 is nonzero
			sqc_s6 <= ((sq_s5 >> F) >= 72'(SQ_CAP)) ? SQ_CAP : SQ_W'(sq_s5 >> F);
			a_l_s7 <= sqc_s6[31:0] * cfg.exponent_gain;
			a_h_s7 <= sqc_s6[60:32] * cfg.exponent_gain;
			a_s8   <= 69'((93'(a_l_s7) + (93'(a_h_s7) << 32)) >> 24);
			ac_s9  <= (a_s8 >= 69'(A_CAP)) ? A_CAP : A_W'(a_s8);
			y_l_s10 <= ac_s9[31:0] * LOG2E_Q30;
			y_h_s10 <= ac_s9[36:32] * LOG2E_Q30;
			y_s11   <= 38'((68'(y_l_s10) + (68'(y_h_s10) << 32)) >> 30);
			big_s12 <= y_s11 >= LIMIT;
			y_s12   <= Y_W'(y_s11);
			for (int k = 6; k <= 12; k++) side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = v_s[12];
	assign y         = y_s12;
	assign big       = big_s12;
	assign side      = side_s[12];
endmodule
`default_nettype wire

FILE: rtl/core/pfs_exp2.sv
// base-2 exponential: quarter table and taylor polynomial, one term per stage
`default_nettype none
module pfs_exp2 #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [FRACTION_BITS+4:0]  y,
	input  logic                      big,
	input  pfs_pkg::side_t            side,
	output logic                      out_valid,
	output logic [pfs_pkg::E_W-1:0]   e,
	output logic                      big_o,
	output pfs_pkg::side_t            side_o
);
	import pfs_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam logic [E_W-1:0] E_SAT = E_W'((64'd1 << (32 + F)) - 64'd1);

	logic [29:0]    f30;
	logic           v_s    [1:9];
	logic           big_s  [1:9];
	side_t          side_s [1:9];
	logic [4:0]     n_s    [1:8];
	logic [1:0]     idx_s  [1:7];
	logic [27:0]    z_s    [1:6];
	logic [31:0]    acc_s  [1:7];
	logic [31:0]    mant_s8;
	logic [E_W-1:0] e_s9;

	assign f30 = 30'(y[F-1:0]) << (30 - F);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 9; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= 9; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[1]    <= 28'((58'(f30[27:0]) * 58'(LN2_Q30)) >> 30);
			idx_s[1]  <= f30[29:28];
			n_s[1]    <= y[F+4:F];
			acc_s[1]  <= taylor_coef(3'd6);
			big_s[1]  <= big;
			side_s[1] <= side;
			// horner step per stage
			for (int k = 1; k <= 6; k++) begin
				acc_s[k+1] <= taylor_coef(3'(6 - k))
				            + 32'((60'(z_s[k]) * 60'(acc_s[k])) >> 30);
				idx_s[k+1] <= idx_s[k];
			end
			for (int k = 2; k <= 6; k++) z_s[k] <= z_s[k-1];
			for (int k = 2; k <= 8; k++) n_s[k] <= n_s[k-1];
			for (int k = 2; k <= 9; k++) begin
				big_s[k]  <= big_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			mant_s8 <= 32'((63'(pow2_quarter(idx_s[7])) * 63'(acc_s[7])) >> 30);
			e_s9    <= big_s[8] ? E_SAT : E_W'((64'(mant_s8) << n_s[8]) >> (30 - F));
		end
	end

	assign out_valid = v_s[9];
	assign e         = e_s9;
	assign big_o     = big_s[9];
	assign side_o    = side_s[9];
endmodule
`default_nettype wire

FILE: rtl/core/pfs_scale.sv
// stress scalar times exponential, then one lane per fibre weight with clipping
`default_nettype none
module pfs_scale #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [pfs_pkg::E_W-1:0] e,
	input  logic                    big,
	input  pfs_pkg::side_t          side,
	input  pfs_pkg::cfg_t           cfg,
	output logic                    out_valid,
	output pfs_pkg::result_t        out_data
);
	import pfs_pkg::*;

	localparam int F = FRACTION_BITS;
	localparam logic [T2_W-1:0] T2_CAP = T2_W'((64'd1 << 61) + (64'd1 << 30));

	logic              v_s   [1:6];
	logic              big_s [1:5];
	logic              neg_s [1:3];
	logic [63:0]       p_ll_s1;
	logic [61:0]       p_lh_s1;
	logic [51:0]       p_hl_s1;
	logic [49:0]       p_hh_s1;
	logic [113:0]      full_s2;
	logic [T2_W-1:0]   t2c_s3;
	logic signed [31:0] w [3];
	logic [31:0]       wmag [3];
	logic              lneg_s4 [3];
	logic              lneg_s5 [3];
	logic [63:0]       m_l_s4 [3];
	logic [61:0]       m_h_s4 [3];
	logic [63:0]       mw_s5 [3];
	logic [63:0]       cap [3];
	logic              clip [3];
	logic [31:0]       mag [3];
	logic [31:0]       stress_s6 [3];
	logic              sat_s6;

	assign w[0] = cfg.fiber_xx;
	assign w[1] = cfg.fiber_xy;
	assign w[2] = cfg.fiber_yy;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wmag[i] = w[i][31] ? 32'(-w[i]) : 32'(w[i]);
			cap[i]  = lneg_s5[i] ? 64'h8000_0000 : 64'h7fff_ffff;
			clip[i] = mw_s5[i] > cap[i];
			mag[i]  = clip[i] ? cap[i][31:0] : mw_s5[i][31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 6; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= 6; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s[1] <= big;
			neg_s[1] <= side.neg;
			for (int k = 2; k <= 5; k++) big_s[k] <= big_s[k-1];
			for (int k = 2; k <= 3; k++) neg_s[k] <= neg_s[k-1];
			p_ll_s1 <= side.t1[31:0] * e[31:0];
			p_lh_s1 <= side.t1[31:0] * e[61:32];
			p_hl_s1 <= side.t1[51:32] * e[31:0];
			p_hh_s1 <= side.t1[51:32] * e[61:32];
			full_s2 <= 114'(p_ll_s1) + ((114'(p_lh_s1) + 114'(p_hl_s1)) << 32)
			         + (114'(p_hh_s1) << 64);
			// any nonzero weight clips once the scalar reaches 2^61 + 2^30
			t2c_s3  <= ((full_s2 >> F) >= 114'(T2_CAP)) ? T2_CAP : T2_W'(full_s2 >> F);
			for (int i = 0; i < 3; i++) begin
				lneg_s4[i] <= neg_s[3] ^ w[i][31];
				m_l_s4[i]  <= t2c_s3[31:0] * wmag[i];
				m_h_s4[i]  <= t2c_s3[61:32] * wmag[i];
				lneg_s5[i] <= lneg_s4[i];
				mw_s5[i]   <= 64'((94'(m_l_s4[i]) + (94'(m_h_s4[i]) << 32)) >> 30);
				stress_s6[i] <= lneg_s5[i] ? 32'(-mag[i]) : mag[i];
			end
			sat_s6 <= big_s[5] | clip[0] | clip[1] | clip[2];
		end
	end

	assign out_valid          = v_s[6];
	assign out_data.stress_xx = stress_s6[0];
	assign out_data.stress_xy = stress_s6[1];
	assign out_data.stress_yy = stress_s6[2];
	assign out_data.saturated = sat_s6;
endmodule
`default_nettype wire

FILE: rtl/core/planar_fiber_stress.sv
// top level of the planar fibre stress block
// planar fibre stress: for each sample of the in-plane deformation tensor the
// block forms the fibre invariant from the configured structure weights,
// scales k1 * invariant by exp(k2 * invariant^2) and returns the three stress
// components, saturated, with a flag when the exponential or a component
// clipped. one item is accepted every clock cycle while the pipeline is not
// held; a result is offered once its sample has passed all 27 arithmetic
// stages (12 for the invariant and exponent argument, 9 for the exponential,
// whose polynomial takes one stage per term, 6 for the stress scaling): the
// first loads at the edge that accepts the sample and the output buffer
// takes the item from the last stage. a two-entry output buffer lets the
// pipeline keep taking items while a finished result waits; the input stalls
// only when that buffer is full and a result is ready to leave the pipeline.
// registers sit on an apb port at byte addresses 0, 4, 8, 12 and 16 and are
// to be written only while no item is in flight.
`default_nettype none
module planar_fiber_stress #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pfs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	pfs_sample_if.sink                 sample,
	pfs_result_if.source               result
);
	import pfs_pkg::*;

	cfg_t                     cfg;
	logic                     en;
	// invariant stage outputs
	logic                     inv_valid;
	logic [FRACTION_BITS+4:0] inv_y;
	logic                     inv_big;
	side_t                    inv_side;
	// exponential stage outputs
	logic                     exp_valid;
	logic [E_W-1:0]           exp_e;
	logic                     exp_big;
	side_t                    exp_side;
	// last pipeline stage
	logic                     sc_valid;
	result_t                  sc_data;
	// output buffer
	result_t                  buf0_q, buf1_q;
	logic [1:0]               count_q;
	logic                     push, pop;

	pfs_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the whole pipeline moves together; it holds only when the buffer is
	// full and the last stage has an item to hand over
	assign en           = !(sc_valid && count_q == 2'd2);
	assign sample.ready = en;

	pfs_inv #(.FRACTION_BITS(FRACTION_BITS)) u_inv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sample.valid),
		.in_data   (sample.data),
		.cfg       (cfg),
		.out_valid (inv_valid),
		.y         (inv_y),
		.big       (inv_big),
		.side      (inv_side)
	);

	pfs_exp2 #(.FRACTION_BITS(FRACTION_BITS)) u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (inv_valid),
		.y         (inv_y),
		.big       (inv_big),
		.side      (inv_side),
		.out_valid (exp_valid),
		.e         (exp_e),
		.big_o     (exp_big),
		.side_o    (exp_side)
	);

	pfs_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (exp_valid),
		.e         (exp_e),
		.big       (exp_big),
		.side      (exp_side),
		.cfg       (cfg),
		.out_valid (sc_valid),
		.out_data  (sc_data)
	);

	// two-entry output buffer, head in buf0
	assign push         = en && sc_valid;
	assign pop          = result.valid && result.ready;
	assign result.valid = count_q != 2'd0;
	assign result.data  = buf0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push && (count_q == 2'd0 || (count_q == 2'd1 && pop))) begin
			buf0_q <= sc_data;
		end else if (pop) begin
			buf0_q <= buf1_q;
		end
		if (push && count_q == 2'd1 && !pop) begin
			buf1_q <= sc_data;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/core/pfs_checker.sv
// port-level checks of the planar fibre stress block, bound to the top level
`default_nettype none
module pfs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input pfs_pkg::result_t           out_data,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [pfs_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata
);
	import pfs_pkg::*;

	logic [5:0] outstanding_q;
	logic       wr;

	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= 6'd0;
		end else begin
			outstanding_q <= outstanding_q + {5'd0, in_valid && in_ready}
			               - {5'd0, out_valid && out_ready};
		end
	end

	// no result without an accepted item behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != 6'd0)
		else $error("result shown with no item in flight");

	// back-pressure bounds the items in flight to pipeline plus buffer
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= 6'd29)
		else $error("too many items in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// a register reads back what was last written to it
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && paddr[ADDR_W-1:2] <= 3'd4) ##1 (psel && !pwrite && paddr == $past(paddr))
		|-> prdata == $past(pwdata))
		else $error("register read back differs from write");
endmodule

bind planar_fiber_stress pfs_checker u_pfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
`default_nettype wire
